// ===== hw/rtl/dct8_pkg.sv =====
// Shared types, widths and shift-add constant multipliers of the 8-point AAN forward DCT.
package dct8_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int COEF_BITS   = 17;
  // Internal headroom: the largest odd output stays below 8 * 2^SAMPLE_BITS.
  localparam int ACC_BITS    = SAMPLE_BITS + 6;
  localparam int STAGES      = 5;

  localparam int RND_16  = 16;
  localparam int RND_32  = 32;
  localparam int RND_64  = 64;
  localparam int RND_128 = 128;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  // ~0.70703
  function automatic acc_t m707(input acc_t x);
    acc_t a32;
    acc_t a128;
    a32  = x + acc_t'(RND_32);
    a128 = x + acc_t'(RND_128);
    return (x >>> 1) + (x >>> 3) + (x >>> 4) + (a32 >>> 6) + (a128 >>> 8);
  endfunction

  // ~0.53906
  function automatic acc_t m541(input acc_t x);
    acc_t a16;
    acc_t a64;
    a16 = x + acc_t'(RND_16);
    a64 = x + acc_t'(RND_64);
    return (x >>> 1) + (a16 >>> 5) + (a64 >>> 7);
  endfunction

  // ~0.38281
  function automatic acc_t m383(input acc_t x);
    acc_t a64;
    a64 = x + acc_t'(RND_64);
    return (x >>> 2) + (x >>> 3) + (a64 >>> 7);
  endfunction

  // ~1.30859
  function automatic acc_t m1307(input acc_t x);
    return x + (x >>> 2) + (x >>> 5) + (x >>> 6) + (x >>> 7) + (x >>> 8);
  endfunction

endpackage

// ===== hw/rtl/dct8_aan_forward.sv =====
// Eight-point forward DCT (AAN flow, unscaled), five-stage pipeline.
//
// Input channel: in_valid / in_stall with sample_0 .. sample_7, one vector per request.
// Output channel: out_valid / out_stall with coef_0 .. coef_7, one result per request.
// A request is taken on a clock edge where valid is high and stall is low.
//
// Path: a taken request passes the stage registers in order (butterflies, even/odd sums,
// constant multipliers, rotation sums, outputs), and its result then waits on the output
// registers until it is taken.
// Throughput: one vector per cycle unless stalled; each multiplier is a fixed shift-add tree.
//
// Stall: each stage loads whenever it is empty or the stage after it moves, so bubbles
// close up; in_stall rises only when all five stages hold data and out_stall is high.
// A stalled result holds its value until taken.
//
// Reset (rst, synchronous): clears all stage valid bits; no result is shown until a
// new request has passed the pipeline. Coefficients wrap to their low 17 bits.
module dct8_aan_forward (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  dct8_pkg::sample_t sample_0,
  input  dct8_pkg::sample_t sample_1,
  input  dct8_pkg::sample_t sample_2,
  input  dct8_pkg::sample_t sample_3,
  input  dct8_pkg::sample_t sample_4,
  input  dct8_pkg::sample_t sample_5,
  input  dct8_pkg::sample_t sample_6,
  input  dct8_pkg::sample_t sample_7,
  output logic             out_valid,
  input  logic             out_stall,
  output dct8_pkg::coef_t  coef_0,
  output dct8_pkg::coef_t  coef_1,
  output dct8_pkg::coef_t  coef_2,
  output dct8_pkg::coef_t  coef_3,
  output dct8_pkg::coef_t  coef_4,
  output dct8_pkg::coef_t  coef_5,
  output dct8_pkg::coef_t  coef_6,
  output dct8_pkg::coef_t  coef_7
);

  logic [dct8_pkg::STAGES-1:0] vld;
  logic [dct8_pkg::STAGES-1:0] en;

  // stage 1: first butterflies
  dct8_pkg::acc_t s07, s16, s25, s34, d07, d16, d25, d34;
  // stage 2: even and odd sums
  dct8_pkg::acc_t e0, e1, e2, e3, o0, o1, o2, d07_2;
  // stage 3: constant multipliers
  dct8_pkg::acc_t c0_3, c4_3, e3_3, r2, rot, p541, p1307, kc, d07_3;
  // stage 4: rotation sums
  dct8_pkg::acc_t c0_4, c4_4, c2_4, c6_4, ka, kb, up, dn;

  // Load a stage when it is empty or its contents move on this edge.
  always_comb begin
    en[dct8_pkg::STAGES-1] = !vld[dct8_pkg::STAGES-1] || !out_stall;
    for (int k = dct8_pkg::STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[dct8_pkg::STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < dct8_pkg::STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      s07 <= dct8_pkg::acc_t'(sample_0) + dct8_pkg::acc_t'(sample_7);
      d07 <= dct8_pkg::acc_t'(sample_0) - dct8_pkg::acc_t'(sample_7);
      s16 <= dct8_pkg::acc_t'(sample_1) + dct8_pkg::acc_t'(sample_6);
      d16 <= dct8_pkg::acc_t'(sample_1) - dct8_pkg::acc_t'(sample_6);
      s25 <= dct8_pkg::acc_t'(sample_2) + dct8_pkg::acc_t'(sample_5);
      d25 <= dct8_pkg::acc_t'(sample_2) - dct8_pkg::acc_t'(sample_5);
      s34 <= dct8_pkg::acc_t'(sample_3) + dct8_pkg::acc_t'(sample_4);
      d34 <= dct8_pkg::acc_t'(sample_3) - dct8_pkg::acc_t'(sample_4);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1] && vld[0]) begin
      e0    <= s07 + s34;
      e3    <= s07 - s34;
      e1    <= s16 + s25;
      e2    <= s16 - s25;
      o0    <= d34 + d25;
      o1    <= d25 + d16;
      o2    <= d16 + d07;
      d07_2 <= d07;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2] && vld[1]) begin
      c0_3  <= e0 + e1;
      c4_3  <= e0 - e1;
      e3_3  <= e3;
      r2    <= dct8_pkg::m707(e2 + e3);
      rot   <= dct8_pkg::m383(o0 - o2);
      p541  <= dct8_pkg::m541(o0);
      p1307 <= dct8_pkg::m1307(o2);
      kc    <= dct8_pkg::m707(o1);
      d07_3 <= d07_2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3] && vld[2]) begin
      c0_4 <= c0_3;
      c4_4 <= c4_3;
      c2_4 <= e3_3 + r2;
      c6_4 <= e3_3 - r2;
      ka   <= p541 + rot;
      kb   <= p1307 + rot;
      up   <= d07_3 + kc;
      dn   <= d07_3 - kc;
    end
  end

  // Output registers; wrap to the coefficient width.
  always_ff @(posedge clk) begin
    if (en[4] && vld[3]) begin
      coef_0 <= dct8_pkg::coef_t'(c0_4);
      coef_4 <= dct8_pkg::coef_t'(c4_4);
      coef_2 <= dct8_pkg::coef_t'(c2_4);
      coef_6 <= dct8_pkg::coef_t'(c6_4);
      coef_1 <= dct8_pkg::coef_t'(dct8_pkg::acc_t'(up + kb));
      coef_7 <= dct8_pkg::coef_t'(dct8_pkg::acc_t'(up - kb));
      coef_5 <= dct8_pkg::coef_t'(dct8_pkg::acc_t'(dn + ka));
      coef_3 <= dct8_pkg::coef_t'(dct8_pkg::acc_t'(dn - ka));
    end
  end

endmodule

// ===== hw/rtl/dct8_checker.sv =====
// Port-level checks of the DCT pipeline, bound to the top level.
module dct8_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input dct8_pkg::sample_t sample_0,
  input dct8_pkg::sample_t sample_1,
  input dct8_pkg::sample_t sample_2,
  input dct8_pkg::sample_t sample_3,
  input dct8_pkg::sample_t sample_4,
  input dct8_pkg::sample_t sample_5,
  input dct8_pkg::sample_t sample_6,
  input dct8_pkg::sample_t sample_7,
  input logic              out_valid,
  input logic              out_stall,
  input dct8_pkg::coef_t   coef_0,
  input dct8_pkg::coef_t   coef_1,
  input dct8_pkg::coef_t   coef_2,
  input dct8_pkg::coef_t   coef_3,
  input dct8_pkg::coef_t   coef_4,
  input dct8_pkg::coef_t   coef_5,
  input dct8_pkg::coef_t   coef_6,
  input dct8_pkg::coef_t   coef_7
);

  logic in_take;
  assign in_take = in_valid && !in_stall;

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  // Input backs up only when the output is full and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output can move");

  // Without output stall, a taken request reaches the output after passing every stage.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_take ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("result missing five cycles after request");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(coef_0) && $stable(coef_1)
      && $stable(coef_2) && $stable(coef_3) && $stable(coef_4) && $stable(coef_5)
      && $stable(coef_6) && $stable(coef_7)))
    else $error("stalled result changed");

endmodule

bind dct8_aan_forward dct8_checker u_dct8_checker (.*);

// ===== bench/dct8_aan_forward_tb.sv =====
// Self-checking testbench for the eight-point AAN forward DCT pipeline.
module dct8_aan_forward_tb;

  localparam int N_RANDOM     = 850;
  localparam int MAX_WAIT     = 12;
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef logic [7:0][dct8_pkg::SAMPLE_BITS-1:0] sample_vec_t;
  typedef logic [7:0][dct8_pkg::COEF_BITS-1:0]   coef_vec_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  dct8_pkg::sample_t sample_0 = '0;
  dct8_pkg::sample_t sample_1 = '0;
  dct8_pkg::sample_t sample_2 = '0;
  dct8_pkg::sample_t sample_3 = '0;
  dct8_pkg::sample_t sample_4 = '0;
  dct8_pkg::sample_t sample_5 = '0;
  dct8_pkg::sample_t sample_6 = '0;
  dct8_pkg::sample_t sample_7 = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  dct8_pkg::coef_t   coef_0, coef_1, coef_2, coef_3, coef_4, coef_5, coef_6, coef_7;

  sample_vec_t vec_q[$];
  coef_vec_t   coef_q[$];
  coef_vec_t   got_vec, want_vec;
  int          send_wait   = 0;
  int          take_wait   = 0;
  int          errors      = 0;
  int          idle_cycles = 0;
  bit          send_calm   = 1'b0;
  bit          take_calm   = 1'b0;

  dct8_aan_forward dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sample_0 (sample_0),
    .sample_1 (sample_1),
    .sample_2 (sample_2),
    .sample_3 (sample_3),
    .sample_4 (sample_4),
    .sample_5 (sample_5),
    .sample_6 (sample_6),
    .sample_7 (sample_7),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .coef_0   (coef_0),
    .coef_1   (coef_1),
    .coef_2   (coef_2),
    .coef_3   (coef_3),
    .coef_4   (coef_4),
    .coef_5   (coef_5),
    .coef_6   (coef_6),
    .coef_7   (coef_7)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Floor shift with an optional rounding offset added first.
  function automatic longint rsh(input longint v, input int s, input longint rnd);
    return (v + rnd) >>> s;
  endfunction

  function automatic longint times_0707(input longint x);
    return rsh(x, 1, 0) + rsh(x, 3, 0) + rsh(x, 4, 0) + rsh(x, 6, dct8_pkg::RND_32)
         + rsh(x, 8, dct8_pkg::RND_128);
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, MAX_WAIT));
  endfunction

  function automatic coef_vec_t dct_coefs(input sample_vec_t s);
    longint    x [8];
    longint    c [8];
    longint    s07, d07, s16, d16, s25, d25, s34, d34;
    longint    e0, e1, e2, e3, r2;
    longint    o0, o1, o2, rot, ka, kb, kc, up, dn;
    coef_vec_t r;
    for (int i = 0; i < 8; i++) x[i] = longint'($signed(s[i]));
    s07 = x[0] + x[7];  d07 = x[0] - x[7];
    s16 = x[1] + x[6];  d16 = x[1] - x[6];
    s25 = x[2] + x[5];  d25 = x[2] - x[5];
    s34 = x[3] + x[4];  d34 = x[3] - x[4];
    // even half
    e0 = s07 + s34;
    e3 = s07 - s34;
    e1 = s16 + s25;
    e2 = s16 - s25;
    r2 = times_0707(e2 + e3);
    c[0] = e0 + e1;
    c[4] = e0 - e1;
    c[2] = e3 + r2;
    c[6] = e3 - r2;
    // odd half: shared rotation, then the 0.541 / 1.307 / 0.707 products
    o0  = d34 + d25;
    o1  = d25 + d16;
    o2  = d16 + d07;
    rot = rsh(o0 - o2, 2, 0) + rsh(o0 - o2, 3, 0) + rsh(o0 - o2, 7, dct8_pkg::RND_64);
    ka  = rsh(o0, 1, 0) + rsh(o0, 5, dct8_pkg::RND_16) + rsh(o0, 7, dct8_pkg::RND_64)
        + rot;
    kb  = o2 + rsh(o2, 2, 0) + rsh(o2, 5, 0) + rsh(o2, 6, 0) + rsh(o2, 7, 0)
        + rsh(o2, 8, 0) + rot;
    kc  = times_0707(o1);
    up  = d07 + kc;
    dn  = d07 - kc;
    c[5] = dn + ka;
    c[3] = dn - ka;
    c[1] = up + kb;
    c[7] = up - kb;
    for (int k = 0; k < 8; k++) r[k] = c[k][dct8_pkg::COEF_BITS-1:0];
    return r;
  endfunction

  // Sender: predict on accept, then hold off or present the next request.
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid)
        coef_q.push_back(dct_coefs({sample_7, sample_6, sample_5, sample_4,
                                    sample_3, sample_2, sample_1, sample_0}));
      if (send_wait != 0) begin
        in_valid  <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (vec_q.size() != 0) begin
        in_valid  <= 1'b1;
        sample_0  <= vec_q[0][0];
        sample_1  <= vec_q[0][1];
        sample_2  <= vec_q[0][2];
        sample_3  <= vec_q[0][3];
        sample_4  <= vec_q[0][4];
        sample_5  <= vec_q[0][5];
        sample_6  <= vec_q[0][6];
        sample_7  <= vec_q[0][7];
        vec_q.delete(0);
        send_wait <= draw_wait(send_calm);
        if ($urandom_range(0, 39) == 0) send_calm <= !send_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: compare each taken result with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      take_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_vec = {coef_7, coef_6, coef_5, coef_4, coef_3, coef_2, coef_1, coef_0};
        if (coef_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result with nothing expected: %h", got_vec);
        end else begin
          want_vec = coef_q.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (got_vec[k] !== want_vec[k]) begin
              errors++;
              if (errors <= MAX_REPORTS)
                $display("coef_%0d: expected %0d, actual %0d", k,
                         $signed(want_vec[k]), $signed(got_vec[k]));
            end
          end
        end
        take_wait = draw_wait(take_calm);
        if ($urandom_range(0, 39) == 0) take_calm <= !take_calm;
      end else if (take_wait != 0) begin
        take_wait = take_wait - 1;
      end
      out_stall <= (take_wait != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sample_vec_t v;
    int          kind;
    // flat, full-scale and alternating vectors
    vec_q.push_back('0);
    vec_q.push_back({8{12'h7FF}});
    vec_q.push_back({8{12'h800}});
    vec_q.push_back({8{12'hFFF}});
    vec_q.push_back({4{12'h800, 12'h7FF}});
    vec_q.push_back({4{12'h7FF, 12'h800}});
    // single-sample impulses at both extremes
    for (int i = 0; i < 8; i++) begin
      v = '0;
      v[i] = 12'h7FF;
      vec_q.push_back(v);
      v[i] = 12'h800;
      vec_q.push_back(v);
    end
    // mostly full-range, some small values to exercise rounding, some extremes
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 8; i++) begin
        if (kind < 6) begin
          v[i] = dct8_pkg::sample_t'($urandom_range(0, 4095));
        end else if (kind < 8) begin
          v[i] = dct8_pkg::sample_t'($urandom_range(0, 512) - 256);
        end else begin
          case ($urandom_range(0, 3))
            0:       v[i] = 12'h800;
            1:       v[i] = 12'h7FF;
            2:       v[i] = 12'h000;
            default: v[i] = 12'hFFF;
          endcase
        end
      end
      vec_q.push_back(v);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (vec_q.size() != 0 || in_valid || coef_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
